// ----- design/vbs_pkg.sv -----
// Shared types and constants of the voxel box statistics block.
package vbs_pkg;

  localparam int IDX_W   = 9;   // widest corner index the block supports
  localparam int ADDR_W  = 15;
  localparam int VAL_W   = 8;
  localparam int FRAC_W  = 17;
  localparam int DEV_W   = 30;
  localparam int CNT_W   = 16;
  localparam int RLIM_W  = 9;
  localparam int DLIM_W  = 14;
  localparam int CFGI_W  = 2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFGI_W-1:0] CFG_RANGE_LIMIT     = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_DEVIATION_LIMIT = 2'd1;

  localparam logic [RLIM_W-1:0] RANGE_LIMIT_RST     = 9'd26;
  localparam logic [DLIM_W-1:0] DEVIATION_LIMIT_RST = 14'd5000;

  localparam logic [15:0] SQ255 = 16'd65025;

  // Classified request handed from the front to the back
  typedef struct packed {
    logic                           op;
    logic [ADDR_W-1:0]              addr;
    logic [VAL_W-1:0]               value;
    logic [2:0][IDX_W-1:0]          lo;
    logic [2:0][IDX_W-1:0]          hi;
    logic                           empty;
  } vbs_req_t;

endpackage

// ----- design/vbs_front.sv -----
// Front end: takes requests, turns corners into indices, queues them.
module vbs_front #(
  parameter int SIDE = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_operation,
  input  logic [vbs_pkg::ADDR_W-1:0] in_voxel_address,
  input  logic [vbs_pkg::VAL_W-1:0]  in_voxel_value,
  input  logic [vbs_pkg::FRAC_W-1:0] in_corner_low_x,
  input  logic [vbs_pkg::FRAC_W-1:0] in_corner_low_y,
  input  logic [vbs_pkg::FRAC_W-1:0] in_corner_low_z,
  input  logic [vbs_pkg::FRAC_W-1:0] in_corner_high_x,
  input  logic [vbs_pkg::FRAC_W-1:0] in_corner_high_y,
  input  logic [vbs_pkg::FRAC_W-1:0] in_corner_high_z,
  output logic                       q_valid,
  output vbs_pkg::vbs_req_t          q_req,
  input  logic                       q_take
);
  import vbs_pkg::*;

  localparam int PW = $clog2(SIDE + 1);
  localparam int MW = FRAC_W + PW;
  localparam logic [PW:0] SIDE_M1 = (PW+1)'(SIDE - 1);

  vbs_req_t         req_c;
  vbs_req_t         q_mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             push;
  logic [FRAC_W-1:0] lo_f [3];
  logic [FRAC_W-1:0] hi_f [3];

  // Scale a fraction by the side and clamp to the last index
  function automatic logic [IDX_W-1:0] corner_idx(input logic [FRAC_W-1:0] f);
    logic [MW-1:0] prod;
    logic [PW:0]   idx;
    prod = MW'(f) * MW'(SIDE);
    idx  = (PW+1)'(prod >> 16);
    if (idx > SIDE_M1) idx = SIDE_M1;
    return IDX_W'(idx);
  endfunction

  assign lo_f[0] = in_corner_low_x;
  assign lo_f[1] = in_corner_low_y;
  assign lo_f[2] = in_corner_low_z;
  assign hi_f[0] = in_corner_high_x;
  assign hi_f[1] = in_corner_high_y;
  assign hi_f[2] = in_corner_high_z;

  // Classify the incoming request
  always_comb begin
    req_c       = '0;
    req_c.op    = in_operation;
    req_c.addr  = in_voxel_address;
    req_c.value = in_voxel_value;
    for (int d = 0; d < 3; d++) begin
      req_c.lo[d] = corner_idx(lo_f[d]);
      req_c.hi[d] = corner_idx(hi_f[d]);
      if (req_c.lo[d] > req_c.hi[d]) req_c.empty = 1'b1;
    end
  end

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_req   = q_mem_r[rd_ptr_r];

  // Hold queue payload
  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= req_c;
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_take) rd_ptr_r <= !rd_ptr_r;
      case ({push, q_take})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- design/vbs_div.sv -----
// Restoring divider, one quotient bit per cycle.
module vbs_div #(
  parameter int DW = 48,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] num,
  input  logic [VW-1:0] den,
  output logic          done,
  output logic [DW-1:0] quo,
  output logic [VW-1:0] rem
);
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [VW:0]   shifted;
  logic          fits;

  assign shifted = {rem_r, quo_r[DW-1]};
  assign fits    = (shifted >= {1'b0, den_r});
  assign done    = done_r;
  assign quo     = quo_r;
  assign rem     = rem_r;

  // Shift one dividend bit in per cycle and subtract where it fits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r <= num;
        rem_r <= '0;
        den_r <= den;
        cnt_r <= CW'(DW);
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= fits ? VW'(shifted - {1'b0, den_r}) : VW'(shifted);
        quo_r <= {quo_r[DW-2:0], fits};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/vbs_back.sv -----
// Back end: voxel memory, box walks and the deviation arithmetic.
module vbs_back #(
  parameter int SIDE = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  vbs_pkg::vbs_req_t          q_req,
  output logic                       q_take,
  input  logic [vbs_pkg::RLIM_W-1:0] range_limit,
  input  logic [vbs_pkg::DLIM_W-1:0] deviation_limit,
  output logic                       out_valid,
  output logic [vbs_pkg::VAL_W-1:0]  out_min_value,
  output logic [vbs_pkg::VAL_W-1:0]  out_max_value,
  output logic [8:0]                 out_level_sum,
  output logic [vbs_pkg::DEV_W-1:0]  out_deviation_sum,
  output logic [vbs_pkg::CNT_W-1:0]  out_voxel_count,
  output logic                       out_empty_box,
  output logic                       out_clear_refine
);
  import vbs_pkg::*;

  localparam int IW    = (SIDE > 2) ? $clog2(SIDE) : 1;
  localparam int STORE = SIDE * SIDE * SIDE;
  localparam int AW    = $clog2(STORE);
  localparam int NW    = $clog2(STORE + 1);
  localparam int SW    = NW + 8;
  localparam int TW    = NW + 16;
  localparam int KW    = TW + 16;
  localparam int VW    = (NW > 16) ? NW : 16;
  localparam int EW    = ((AW > ADDR_W) ? AW : ADDR_W) + 1;
  localparam logic [AW-1:0] STEP_Y = AW'(SIDE);
  localparam logic [AW-1:0] STEP_Z = AW'(SIDE * SIDE);
  localparam logic [EW-1:0] STORE_E = EW'(STORE);

  typedef enum logic [3:0] {
    ST_IDLE, ST_WALK, ST_DRAIN, ST_DIV_MEAN, ST_MUL, ST_DIV_W,
    ST_DIV_P, ST_SPLIT, ST_REDUCE, ST_DONE
  } state_t;

  state_t          state_r;
  logic            pass2_r;
  logic            div_wait_r;
  logic [IW-1:0]   lo_r [3];
  logic [IW-1:0]   hi_r [3];
  logic [IW-1:0]   x_r, y_r, z_r;
  logic [AW-1:0]   ay_r, az_r, ay_base_r, az_base_r;
  logic            rd_vld_r;
  logic [VAL_W-1:0] rd_data_r;
  logic [VAL_W-1:0] mem [STORE];
  logic [VAL_W-1:0] vmin_r, vmax_r;
  logic [NW-1:0]   n_r;
  logic [SW-1:0]   s_r;
  logic [TW-1:0]   t_r;
  logic [VAL_W-1:0] a_r;
  logic [NW-1:0]   b_r;
  logic [2*NW-1:0] bb_r;
  logic [NW-1:0]   w_r, remw_r, sr_r;
  logic [16:0]     p_r;
  logic [KW-1:0]   q_r;
  logic [15:0]     r_r;
  logic [KW-1:0]   red_r;

  logic [AW-1:0]   rd_addr;
  logic            rd_en;
  logic            wr_en;
  logic            last;
  logic [VAL_W-1:0] dd;
  logic [TW-1:0]   u;
  logic [KW-1:0]   k;
  logic            div_start, div_done;
  logic [KW-1:0]   div_num, div_quo;
  logic [VW-1:0]   div_den, div_rem;
  logic [KW-17:0]  red_hi;
  logic [KW-1:0]   red_nxt;
  logic            red_fits;
  logic            round_up;
  logic [KW:0]     q_rnd;
  logic [DEV_W-1:0] dev;

  assign q_take  = (state_r == ST_IDLE) && q_valid;
  assign wr_en   = q_take && (q_req.op == OP_LOAD)
                   && (EW'(q_req.addr) < STORE_E);
  assign rd_en   = (state_r == ST_WALK);
  assign rd_addr = AW'(x_r) + ay_r + az_r;
  assign last    = (x_r == hi_r[0]) && (y_r == hi_r[1]) && (z_r == hi_r[2]);
  assign dd      = (rd_data_r >= a_r) ? rd_data_r - a_r : a_r - rd_data_r;
  assign u       = t_r - TW'(w_r);
  assign k       = {u, 16'd0} - KW'(p_r) - KW'(sr_r != '0);

  // Fold the high part back in: 65025 = 2^16 - 511, so hi * 2^16 == hi * 511
  assign red_hi   = red_r[KW-1:16];
  assign red_nxt  = KW'({red_hi, 9'd0}) - KW'(red_hi) + KW'(red_r[15:0]);
  assign red_fits = (red_r[15:0] >= SQ255);

  // Voxel memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[AW'(q_req.addr)] <= q_req.value;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // Select the dividend of the shared divider; the divisor is the count
  always_comb begin
    div_num = KW'(s_r);
    case (state_r)
      ST_DIV_W: div_num = KW'(bb_r);
      ST_DIV_P: div_num = KW'({remw_r, 16'd0});
      default:  div_num = KW'(s_r);
    endcase
  end

  assign div_den   = VW'(n_r);
  assign div_start = !div_wait_r && (state_r == ST_DIV_MEAN || state_r == ST_DIV_W
                     || state_r == ST_DIV_P);

  vbs_div #(.DW(KW), .VW(VW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // Round to nearest with the fractional tail, then saturate
  always_comb begin
    round_up = ({r_r, 1'b0} >= {1'b0, SQ255})
               || (({r_r, 1'b0} == {1'b0, SQ255} - 17'd1) && (sr_r != '0)
                   && ({1'b0, n_r - sr_r, 1'b0} >= {2'b0, n_r}));
    q_rnd = {1'b0, q_r} + (KW+1)'(round_up);
    dev   = (q_rnd > (KW+1)'({DEV_W{1'b1}})) ? {DEV_W{1'b1}} : DEV_W'(q_rnd);
  end

  // Sequence the walks and arithmetic steps; hold results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      div_wait_r <= 1'b0;
      rd_vld_r   <= 1'b0;
      out_valid  <= 1'b0;
      pass2_r    <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      rd_vld_r  <= rd_en;
      if (div_start) div_wait_r <= 1'b1;

      // accumulate the registered voxel read
      if (rd_vld_r) begin
        if (!pass2_r) begin
          if (rd_data_r < vmin_r) vmin_r <= rd_data_r;
          if (rd_data_r > vmax_r) vmax_r <= rd_data_r;
          s_r <= s_r + SW'(rd_data_r);
          n_r <= n_r + NW'(1);
        end else begin
          t_r <= t_r + TW'(dd * dd);
        end
      end

      unique case (state_r)
        ST_IDLE: begin
          if (q_take && q_req.op == OP_QUERY) begin
            if (q_req.empty) begin
              out_valid         <= 1'b1;
              out_min_value     <= 8'd255;
              out_max_value     <= 8'd0;
              out_level_sum     <= 9'd255;
              out_deviation_sum <= '0;
              out_voxel_count   <= '0;
              out_empty_box     <= 1'b1;
              out_clear_refine  <= 1'b1;
            end else begin
              for (int d = 0; d < 3; d++) begin
                lo_r[d] <= IW'(q_req.lo[d]);
                hi_r[d] <= IW'(q_req.hi[d]);
              end
              x_r       <= IW'(q_req.lo[0]);
              y_r       <= IW'(q_req.lo[1]);
              z_r       <= IW'(q_req.lo[2]);
              ay_r      <= AW'(AW'(q_req.lo[1]) * STEP_Y);
              az_r      <= AW'(AW'(q_req.lo[2]) * STEP_Z);
              ay_base_r <= AW'(AW'(q_req.lo[1]) * STEP_Y);
              az_base_r <= AW'(AW'(q_req.lo[2]) * STEP_Z);
              vmin_r    <= 8'd255;
              vmax_r    <= 8'd0;
              s_r       <= '0;
              n_r       <= '0;
              t_r       <= '0;
              pass2_r   <= 1'b0;
              state_r   <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (last) begin
            state_r <= ST_DRAIN;
          end else if (z_r != hi_r[2]) begin
            z_r  <= z_r + IW'(1);
            az_r <= az_r + STEP_Z;
          end else begin
            z_r  <= lo_r[2];
            az_r <= az_base_r;
            if (y_r != hi_r[1]) begin
              y_r  <= y_r + IW'(1);
              ay_r <= ay_r + STEP_Y;
            end else begin
              y_r  <= lo_r[1];
              ay_r <= ay_base_r;
              x_r  <= x_r + IW'(1);
            end
          end
        end
        ST_DRAIN: begin
          // rewind the walk for the second pass
          x_r  <= lo_r[0];
          y_r  <= lo_r[1];
          z_r  <= lo_r[2];
          ay_r <= ay_base_r;
          az_r <= az_base_r;
          state_r <= pass2_r ? ST_DIV_P : ST_DIV_MEAN;
        end
        ST_DIV_MEAN: begin
          if (div_done) begin
            a_r        <= div_quo[VAL_W-1:0];
            b_r        <= div_rem[NW-1:0];
            div_wait_r <= 1'b0;
            state_r    <= ST_MUL;
          end
        end
        ST_MUL: begin
          bb_r    <= b_r * b_r;
          state_r <= ST_DIV_W;
        end
        ST_DIV_W: begin
          if (div_done) begin
            w_r        <= div_quo[NW-1:0];
            remw_r     <= div_rem[NW-1:0];
            div_wait_r <= 1'b0;
            pass2_r    <= 1'b1;
            state_r    <= ST_WALK;
          end
        end
        ST_DIV_P: begin
          if (div_done) begin
            p_r        <= div_quo[16:0];
            sr_r       <= div_rem[NW-1:0];
            div_wait_r <= 1'b0;
            state_r    <= ST_SPLIT;
          end
        end
        ST_SPLIT: begin
          red_r   <= k;
          q_r     <= '0;
          state_r <= ST_REDUCE;
        end
        ST_REDUCE: begin
          // fold until the remainder fits 16 bits, then one compare and subtract
          if (red_hi != '0) begin
            q_r   <= q_r + KW'(red_hi);
            red_r <= red_nxt;
          end else begin
            q_r     <= q_r + KW'(red_fits);
            r_r     <= red_fits ? red_r[15:0] - SQ255 : red_r[15:0];
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          out_valid         <= 1'b1;
          out_min_value     <= vmin_r;
          out_max_value     <= vmax_r;
          out_level_sum     <= {1'b0, vmin_r} + {1'b0, vmax_r};
          out_deviation_sum <= dev;
          out_voxel_count   <= (n_r > NW'(16'hFFFF)) ? 16'hFFFF : CNT_W'(n_r);
          out_empty_box     <= 1'b0;
          out_clear_refine  <= ({1'b0, vmax_r - vmin_r} < range_limit)
                               || (dev < {deviation_limit, 16'd0});
          pass2_r           <= 1'b0;
          state_r           <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- design/voxel_box_statistics_top.sv -----
// Voxel box statistics top level: configuration registers, front and back.
//
// A load request writes one voxel as the back end takes it and leaves the
// back end idle. A query produces one result: an empty box answers in the
// cycle after the back end takes it; otherwise the single memory read port
// walks the box twice, one voxel per cycle, around three shared divisions
// and a short fold by 255^2. A two-entry queue sits in front; busy rises
// when it is full. Results appear on out_valid for one cycle each and
// cannot be held off. Write configuration only when idle.
module voxel_box_statistics_top #(
  parameter int VOLUME_SIDE = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_operation,
  input  logic [vbs_pkg::ADDR_W-1:0] in_voxel_address,
  input  logic [vbs_pkg::VAL_W-1:0]  in_voxel_value,
  input  logic [vbs_pkg::FRAC_W-1:0] in_corner_low_x,
  input  logic [vbs_pkg::FRAC_W-1:0] in_corner_low_y,
  input  logic [vbs_pkg::FRAC_W-1:0] in_corner_low_z,
  input  logic [vbs_pkg::FRAC_W-1:0] in_corner_high_x,
  input  logic [vbs_pkg::FRAC_W-1:0] in_corner_high_y,
  input  logic [vbs_pkg::FRAC_W-1:0] in_corner_high_z,
  input  logic                       cfg_we,
  input  logic [vbs_pkg::CFGI_W-1:0] cfg_index,
  input  logic [vbs_pkg::DLIM_W-1:0] cfg_wdata,
  output logic                       out_valid,
  output logic [vbs_pkg::VAL_W-1:0]  out_min_value,
  output logic [vbs_pkg::VAL_W-1:0]  out_max_value,
  output logic [8:0]                 out_level_sum,
  output logic [vbs_pkg::DEV_W-1:0]  out_deviation_sum,
  output logic [vbs_pkg::CNT_W-1:0]  out_voxel_count,
  output logic                       out_empty_box,
  output logic                       out_clear_refine
);
  import vbs_pkg::*;

  logic [RLIM_W-1:0] range_limit_r;
  logic [DLIM_W-1:0] deviation_limit_r;
  logic              q_valid;
  logic              q_take;
  vbs_req_t          q_req;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_limit_r     <= RANGE_LIMIT_RST;
      deviation_limit_r <= DEVIATION_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RANGE_LIMIT:     range_limit_r     <= cfg_wdata[RLIM_W-1:0];
        CFG_DEVIATION_LIMIT: deviation_limit_r <= cfg_wdata;
        default:             range_limit_r     <= range_limit_r;
      endcase
    end
  end

  vbs_front #(.SIDE(VOLUME_SIDE)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_voxel_address (in_voxel_address),
    .in_voxel_value   (in_voxel_value),
    .in_corner_low_x  (in_corner_low_x),
    .in_corner_low_y  (in_corner_low_y),
    .in_corner_low_z  (in_corner_low_z),
    .in_corner_high_x (in_corner_high_x),
    .in_corner_high_y (in_corner_high_y),
    .in_corner_high_z (in_corner_high_z),
    .q_valid          (q_valid),
    .q_req            (q_req),
    .q_take           (q_take)
  );

  vbs_back #(.SIDE(VOLUME_SIDE)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_req             (q_req),
    .q_take            (q_take),
    .range_limit       (range_limit_r),
    .deviation_limit   (deviation_limit_r),
    .out_valid         (out_valid),
    .out_min_value     (out_min_value),
    .out_max_value     (out_max_value),
    .out_level_sum     (out_level_sum),
    .out_deviation_sum (out_deviation_sum),
    .out_voxel_count   (out_voxel_count),
    .out_empty_box     (out_empty_box),
    .out_clear_refine  (out_clear_refine)
  );

endmodule
